/* rtl/four_level_page_walker_unit_assert.svh */
// assertion macros used by the checker file
`ifndef FOUR_LEVEL_PAGE_WALKER_UNIT_ASSERT_SVH
`define FOUR_LEVEL_PAGE_WALKER_UNIT_ASSERT_SVH

// property that holds in the same cycle
`define PWU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define PWU_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

/* rtl/pwu_pkg.sv */
`default_nettype none
package pwu_pkg;

    localparam int VA_W    = 48;
    localparam int PA_W    = 52;
    localparam int ENTRY_W = 64;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_ENTRY = 1'b1;

    localparam logic [1:0] KIND_REQ   = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_FAULT = 2'd2;

    localparam logic [1:0] LEVEL_TOP  = 2'd0;
    localparam logic [1:0] LEVEL_1G   = 2'd1;
    localparam logic [1:0] LEVEL_2M   = 2'd2;
    localparam logic [1:0] LEVEL_LEAF = 2'd3;

    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    typedef struct packed {
        logic               command;
        logic [VA_W-1:0]    virt_addr;
        logic [ENTRY_W-1:0] entry_data;
    } pwu_req_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [PA_W-1:0] address;
        logic [1:0]      level;
    } pwu_res_t;

    typedef struct packed {
        logic            busy;
        logic [1:0]      walk_level;
        logic [VA_W-1:0] held_vaddr;
    } pwu_walk_t;

endpackage
`default_nettype wire

/* rtl/pwu_step.sv */
`default_nettype none
module pwu_step
(
    input  wire pwu_pkg::pwu_req_t      item,
    input  wire pwu_pkg::pwu_walk_t     walk,
    input  wire [pwu_pkg::PA_W-1:0]     table_root,
    output pwu_pkg::pwu_walk_t          walk_next,
    output pwu_pkg::pwu_res_t           result,
    output logic                        has_result
);

    logic [pwu_pkg::ENTRY_W-1:0] ent;
    logic [pwu_pkg::VA_W-1:0]    va;
    logic [1:0]                  lvl_up;
    logic [8:0]                  idx_up;
    logic                        present;
    logic                        page_size;

    assign ent       = item.entry_data;
    assign va        = walk.held_vaddr;
    assign lvl_up    = walk.walk_level + 2'd1;
    assign present   = ent[pwu_pkg::PRESENT_BIT];
    assign page_size = ent[pwu_pkg::LARGE_BIT];

    // table index for the level about to be requested
    always_comb
    begin
        unique case (lvl_up)
            pwu_pkg::LEVEL_1G:   idx_up = va[38:30];
            pwu_pkg::LEVEL_2M:   idx_up = va[29:21];
            pwu_pkg::LEVEL_LEAF: idx_up = va[20:12];
            default:             idx_up = va[47:39];
        endcase
    end

    always_comb
    begin
        walk_next      = walk;
        has_result     = 1'b0;
        result.kind    = pwu_pkg::KIND_REQ;
        result.address = '0;
        result.level   = walk.walk_level;
        if (item.command == pwu_pkg::CMD_START)
        begin
            walk_next.busy       = 1'b1;
            walk_next.walk_level = pwu_pkg::LEVEL_TOP;
            walk_next.held_vaddr = item.virt_addr;
            has_result           = 1'b1;
            result.address       = {table_root[51:12], item.virt_addr[47:39], 3'b000};
            result.level         = pwu_pkg::LEVEL_TOP;
        end
        else if (walk.busy)
        begin
            has_result = 1'b1;
            if (!present)
            begin
                walk_next.busy = 1'b0;
                result.kind    = pwu_pkg::KIND_FAULT;
            end
            else if (walk.walk_level == pwu_pkg::LEVEL_1G && page_size)
            begin
                walk_next.busy = 1'b0;
                result.kind    = pwu_pkg::KIND_DONE;
                result.address = {ent[51:30], va[29:0]};
            end
            else if (walk.walk_level == pwu_pkg::LEVEL_2M && page_size)
            begin
                walk_next.busy = 1'b0;
                result.kind    = pwu_pkg::KIND_DONE;
                result.address = {ent[51:21], va[20:0]};
            end
            else if (walk.walk_level == pwu_pkg::LEVEL_LEAF)
            begin
                walk_next.busy = 1'b0;
                result.kind    = pwu_pkg::KIND_DONE;
                result.address = {ent[51:12], va[11:0]};
            end
            else
            begin
                walk_next.walk_level = lvl_up;
                result.address       = {ent[51:12], idx_up, 3'b000};
                result.level         = lvl_up;
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/pwu_out_stage.sv */
`default_nettype none
module pwu_out_stage
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      load,
    input  wire pwu_pkg::pwu_res_t   load_data,
    output logic                     space,
    output logic                     res_valid,
    input  wire                      res_ready,
    output pwu_pkg::pwu_res_t        res
);

    logic              valid_reg;
    logic              valid_next;
    pwu_pkg::pwu_res_t data_reg;

    assign space      = !valid_reg || res_ready;
    assign valid_next = load || (valid_reg && !res_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign res_valid = valid_reg;
    assign res       = data_reg;

endmodule
`default_nettype wire

/* rtl/four_level_page_walker_unit.sv */
`default_nettype none
// four-level page-table walker. a start request (command 0) latches the virtual
// address and returns a read request for the top-level entry under table_root;
// each entry request (command 1) returns the next read request, a done result
// with the physical address (1 GiB, 2 MiB or 4 KiB page) or a not-present fault.
// an entry request while no walk is open gives no result; a start abandons any
// open walk. one request is taken per cycle while none is held off: it passes
// through an input register, one level of walk logic, and an output register,
// which holds its result until it is taken. a result left waiting at the output
// holds off the next request that makes a result.
// write table_root only while idle.
module four_level_page_walker_unit
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       table_root_we,
    input  wire [pwu_pkg::PA_W-1:0]   table_root_wdata,
    input  wire                       req_valid,
    output logic                      req_ready,
    input  wire pwu_pkg::pwu_req_t    req,
    output logic                      res_valid,
    input  wire                       res_ready,
    output pwu_pkg::pwu_res_t         res
);

    logic [pwu_pkg::PA_W-1:0] table_root_reg;
    logic                     item_valid_reg;
    pwu_pkg::pwu_req_t        item_reg;
    pwu_pkg::pwu_walk_t       walk_reg;
    pwu_pkg::pwu_walk_t       walk_next;
    pwu_pkg::pwu_res_t        step_res;
    logic                     step_has_res;
    logic                     out_space;
    logic                     advance;
    logic                     item_valid_next;

    assign advance         = item_valid_reg && (!step_has_res || out_space);
    assign req_ready       = !item_valid_reg || advance;
    assign item_valid_next = (req_valid && req_ready) || (item_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            table_root_reg <= '0;
            item_valid_reg <= 1'b0;
            walk_reg       <= '0;
        end
        else
        begin
            if (table_root_we)
            begin
                table_root_reg <= table_root_wdata;
            end
            item_valid_reg <= item_valid_next;
            if (advance)
            begin
                walk_reg <= walk_next;
            end
        end
    end

    // request holding register
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            item_reg <= req;
        end
    end

    pwu_step u_step
    (
        .item       (item_reg),
        .walk       (walk_reg),
        .table_root (table_root_reg),
        .walk_next  (walk_next),
        .result     (step_res),
        .has_result (step_has_res)
    );

    pwu_out_stage u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && step_has_res),
        .load_data (step_res),
        .space     (out_space),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule
`default_nettype wire

/* rtl/pwu_checker.sv */
`default_nettype none
`include "four_level_page_walker_unit_assert.svh"
module pwu_checker
(
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      res_valid,
    input  wire                      res_ready,
    input  wire pwu_pkg::pwu_res_t   res
);

    // a waiting result stays
    `PWU_ASSERT_NEXT(a_res_hold, clk, rst_n, res_valid && !res_ready, res_valid, "result dropped")

    `PWU_ASSERT(a_kind_legal, clk, rst_n, !res_valid || res.kind == pwu_pkg::KIND_REQ || res.kind == pwu_pkg::KIND_DONE || res.kind == pwu_pkg::KIND_FAULT, "bad result kind")

    `PWU_ASSERT(a_fault_addr, clk, rst_n, !(res_valid && res.kind == pwu_pkg::KIND_FAULT) || res.address == '0, "fault with address")

    `PWU_ASSERT(a_done_level, clk, rst_n, !(res_valid && res.kind == pwu_pkg::KIND_DONE) || res.level != pwu_pkg::LEVEL_TOP, "done at top level")

    `PWU_ASSERT(a_req_align, clk, rst_n, !(res_valid && res.kind == pwu_pkg::KIND_REQ) || res.address[2:0] == 3'b000, "unaligned entry read")

endmodule

bind four_level_page_walker_unit pwu_checker u_pwu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);
`default_nettype wire

/* dv/tb_top.sv */
module tb_top;

    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 10;
    localparam int MAX_ERR_SHOWN = 10;

    localparam int RDY_ALWAYS   = 0;
    localparam int RDY_RANDOM   = 1;
    localparam int RDY_PERIODIC = 2;

    typedef struct {
        pwu_pkg::pwu_req_t r;
        bit                drain;
        bit                typed;
        bit                want;
        pwu_pkg::pwu_res_t res;
    } pend_req_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     table_root_we = 1'b0;
    logic [pwu_pkg::PA_W-1:0] table_root_wdata = '0;
    logic                     req_valid = 1'b0;
    logic                     req_ready;
    pwu_pkg::pwu_req_t        req = '0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    pwu_pkg::pwu_res_t        res;

    // walker state as predicted
    logic                     walk_busy = 1'b0;
    logic [1:0]               walk_lvl = pwu_pkg::LEVEL_TOP;
    logic [pwu_pkg::VA_W-1:0] walk_va = '0;
    logic [pwu_pkg::PA_W-1:0] root_reg = '0;

    pend_req_t         stim_q[$];
    pend_req_t         dir_tab[$];
    pwu_pkg::pwu_res_t res_due_q[$];
    pend_req_t         cur_item;

    int cycle_count = 0;
    int err_count = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_done = 0;
    int n_fault = 0;
    int n_walks = 0;
    int n_roots = 0;
    int n_pauses = 0;
    int burst_left = 0;
    int gap_left = 0;
    int mode_left = 0;
    int stall_mode = RDY_ALWAYS;
    logic [1:0] stall_phase = '0;

    four_level_page_walker_unit dut
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .table_root_we    (table_root_we),
        .table_root_wdata (table_root_wdata),
        .req_valid        (req_valid),
        .req_ready        (req_ready),
        .req              (req),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [8:0] tbl_index(input logic [pwu_pkg::VA_W-1:0] va,
                                             input logic [1:0] lvl);
        case (lvl)
            pwu_pkg::LEVEL_TOP: return va[47:39];
            pwu_pkg::LEVEL_1G:  return va[38:30];
            pwu_pkg::LEVEL_2M:  return va[29:21];
            default:            return va[20:12];
        endcase
    endfunction

    function automatic logic translate_step(input pwu_pkg::pwu_req_t r,
                                            output pwu_pkg::pwu_res_t o);
        logic [pwu_pkg::ENTRY_W-1:0] e;
        o = '0;
        e = r.entry_data;
        if (r.command == pwu_pkg::CMD_START)
        begin
            walk_va   = r.virt_addr;
            walk_lvl  = pwu_pkg::LEVEL_TOP;
            walk_busy = 1'b1;
            o.kind    = pwu_pkg::KIND_REQ;
            o.address = {root_reg[51:12], tbl_index(r.virt_addr, pwu_pkg::LEVEL_TOP), 3'b000};
            o.level   = pwu_pkg::LEVEL_TOP;
            return 1'b1;
        end
        if (!walk_busy)
            return 1'b0;
        o.level = walk_lvl;
        if (!e[pwu_pkg::PRESENT_BIT])
        begin
            walk_busy = 1'b0;
            o.kind    = pwu_pkg::KIND_FAULT;
        end
        else if (walk_lvl == pwu_pkg::LEVEL_1G && e[pwu_pkg::LARGE_BIT])
        begin
            walk_busy = 1'b0;
            o.kind    = pwu_pkg::KIND_DONE;
            o.address = {e[51:30], walk_va[29:0]};
        end
        else if (walk_lvl == pwu_pkg::LEVEL_2M && e[pwu_pkg::LARGE_BIT])
        begin
            walk_busy = 1'b0;
            o.kind    = pwu_pkg::KIND_DONE;
            o.address = {e[51:21], walk_va[20:0]};
        end
        else if (walk_lvl == pwu_pkg::LEVEL_LEAF)
        begin
            walk_busy = 1'b0;
            o.kind    = pwu_pkg::KIND_DONE;
            o.address = {e[51:12], walk_va[11:0]};
        end
        else
        begin
            walk_lvl  = walk_lvl + 2'd1;
            o.kind    = pwu_pkg::KIND_REQ;
            o.address = {e[51:12], tbl_index(walk_va, walk_lvl), 3'b000};
            o.level   = walk_lvl;
        end
        return 1'b1;
    endfunction

    function automatic pend_req_t mk_req(input logic cmd, input logic [pwu_pkg::VA_W-1:0] va,
                                         input logic [pwu_pkg::ENTRY_W-1:0] ent);
        pend_req_t p;
        p.r.command    = cmd;
        p.r.virt_addr  = va;
        p.r.entry_data = ent;
        p.drain = 1'b0;
        p.typed = 1'b0;
        p.want  = 1'b0;
        p.res   = '0;
        return p;
    endfunction

    task automatic row(input logic cmd, input logic [pwu_pkg::VA_W-1:0] va,
                       input logic [pwu_pkg::ENTRY_W-1:0] ent);
        dir_tab.push_back(mk_req(cmd, va, ent));
    endtask

    task automatic row_exp(input logic cmd, input logic [pwu_pkg::VA_W-1:0] va,
                           input logic [pwu_pkg::ENTRY_W-1:0] ent, input bit want,
                           input logic [1:0] kind, input logic [pwu_pkg::PA_W-1:0] addr,
                           input logic [1:0] lvl);
        pend_req_t p;
        p = mk_req(cmd, va, ent);
        p.typed       = 1'b1;
        p.want        = want;
        p.res.kind    = kind;
        p.res.address = addr;
        p.res.level   = lvl;
        dir_tab.push_back(p);
    endtask

    function automatic logic [pwu_pkg::ENTRY_W-1:0] rand_ent();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [pwu_pkg::VA_W-1:0] rand_va();
        logic [15:0] hi;
        int pick;
        pick = $urandom_range(0, 9);
        hi = 16'($urandom_range(0, 16'hFFFF));
        if (pick == 0)
            return '0;
        if (pick == 1)
            return '1;
        return {hi, $urandom};
    endfunction

    task automatic gen_walks(input int n);
        int made;
        int pick;
        int lvl;
        bit mid_drain;
        pend_req_t p;
        logic [pwu_pkg::ENTRY_W-1:0] e;
        made = 0;
        mid_drain = 1'b0;
        while (made < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 90)
            begin
                p = mk_req(pwu_pkg::CMD_START, rand_va(), rand_ent());
                if ((!mid_drain && made >= n / 2) || $urandom_range(0, 39) == 0)
                begin
                    p.drain = 1'b1;
                    mid_drain = 1'b1;
                end
                stim_q.push_back(p);
                made++;
                n_walks++;
                lvl = 0;
                // lone starts skip the entries
                while (pick < 80 && lvl < 4 && $urandom_range(0, 19) != 0)
                begin
                    e = rand_ent();
                    e[pwu_pkg::PRESENT_BIT] = ($urandom_range(0, 9) != 0);
                    e[pwu_pkg::LARGE_BIT]   = ($urandom_range(0, 2) == 0);
                    stim_q.push_back(mk_req(pwu_pkg::CMD_ENTRY, rand_va(), e));
                    made++;
                    if (!e[pwu_pkg::PRESENT_BIT]
                        || ((lvl == 1 || lvl == 2) && e[pwu_pkg::LARGE_BIT]))
                        break;
                    lvl++;
                end
            end
            else
            begin
                // stray entry, often with no walk open
                stim_q.push_back(mk_req(pwu_pkg::CMD_ENTRY, rand_va(), rand_ent()));
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(stim_q.size() == 0 && !req_valid && res_due_q.size() == 0));
    endtask

    task automatic write_root(input logic [pwu_pkg::PA_W-1:0] v);
        wait_drained();
        repeat (8) @(negedge clk);
        @(posedge clk);
        table_root_we    <= 1'b1;
        table_root_wdata <= v;
        @(posedge clk);
        table_root_we    <= 1'b0;
        root_reg = v;
        n_roots++;
    endtask

    // request side
    always @(posedge clk)
    begin
        pwu_pkg::pwu_res_t pr;
        logic got;
        logic drive;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
        end
        else
        begin
            drive = 1'b0;
            if (req_valid && req_ready)
            begin
                got = translate_step(cur_item.r, pr);
                if (cur_item.typed)
                begin
                    if (cur_item.want)
                        res_due_q.push_back(cur_item.res);
                end
                else if (got)
                begin
                    res_due_q.push_back(pr);
                end
                n_sent++;
            end
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (stim_q.size() > 0 && !(stim_q[0].drain && res_due_q.size() > 0))
                begin
                    cur_item = stim_q.pop_front();
                    if (cur_item.drain)
                        n_pauses++;
                    drive = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 6);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
                req_valid <= drive;
                if (drive)
                    req <= cur_item.r;
            end
        end
    end

    // result side
    always @(posedge clk)
    begin
        pwu_pkg::pwu_res_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (res_due_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= MAX_ERR_SHOWN)
                        $display("unexpected result: kind %0d addr %h level %0d",
                                 res.kind, res.address, res.level);
                end
                else
                begin
                    want = res_due_q.pop_front();
                    if (res.kind !== want.kind || res.address !== want.address
                        || res.level !== want.level)
                    begin
                        err_count++;
                        if (err_count <= MAX_ERR_SHOWN)
                            $display({"mismatch: expected kind %0d addr %h level %0d, ",
                                      "got kind %0d addr %h level %0d"},
                                     want.kind, want.address, want.level,
                                     res.kind, res.address, res.level);
                    end
                    else
                    begin
                        n_checked++;
                        if (res.kind == pwu_pkg::KIND_DONE)
                            n_done++;
                        if (res.kind == pwu_pkg::KIND_FAULT)
                            n_fault++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(RDY_ALWAYS, RDY_PERIODIC);
                mode_left = $urandom_range(16, 96);
            end
            else
            begin
                mode_left--;
            end
            case (stall_mode)
                RDY_ALWAYS: res_ready <= 1'b1;
                RDY_RANDOM: res_ready <= ($urandom_range(0, 1) == 1);
                default:
                begin
                    stall_phase = stall_phase + 2'd1;
                    res_ready <= (stall_phase == 2'b00);
                end
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, res_due_q.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [19:0] root_hi;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset value of table_root
        row_exp(pwu_pkg::CMD_START, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1,
                pwu_pkg::KIND_REQ, 52'h0, pwu_pkg::LEVEL_TOP);
        row_exp(pwu_pkg::CMD_ENTRY, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b1,
                pwu_pkg::KIND_FAULT, 52'h0, pwu_pkg::LEVEL_TOP);
        row_exp(pwu_pkg::CMD_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0,
                pwu_pkg::KIND_REQ, 52'h0, pwu_pkg::LEVEL_TOP);
        row_exp(pwu_pkg::CMD_START, 48'hFFFF_FFFF_FFFF, 64'h0, 1'b1,
                pwu_pkg::KIND_REQ, 52'hFF8, pwu_pkg::LEVEL_TOP);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        row_exp(pwu_pkg::CMD_ENTRY, 48'h0, 64'h80, 1'b1,
                pwu_pkg::KIND_FAULT, 52'h0, pwu_pkg::LEVEL_1G);
        row(pwu_pkg::CMD_START, 48'h1234_5678_9ABC, 64'h0);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h0000_0123_4567_8003);
        row(pwu_pkg::CMD_START, 48'hFEDC_BA98_7654, 64'h0);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h8000_0ABC_DEF0_1001);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        row(pwu_pkg::CMD_START, 48'hFFFF_FFFF_FFFF, 64'h0);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h0007_FFFF_FFFF_F001);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h7FF0_0000_0000_0F01);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        row(pwu_pkg::CMD_START, 48'h8000_4020_1008, 64'h0);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h0000_0000_0000_1001);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h000F_FFFF_FFFF_F07F);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h0000_0000_0000_2001);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        row(pwu_pkg::CMD_START, 48'h0000_7FFF_F000, 64'h0);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h1);
        row(pwu_pkg::CMD_ENTRY, 48'h0, 64'h1);
        row_exp(pwu_pkg::CMD_ENTRY, 48'h0, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1,
                pwu_pkg::KIND_FAULT, 52'h0, pwu_pkg::LEVEL_2M);

        @(negedge clk);
        foreach (dir_tab[i])
            stim_q.push_back(dir_tab[i]);

        write_root(52'hF_FFFF_FFFF_FFFF);
        gen_walks(150);
        write_root(52'h0);
        gen_walks(150);
        root_hi = 20'($urandom_range(0, 20'hFFFFF));
        write_root({root_hi, $urandom});
        gen_walks(150);
        root_hi = 20'($urandom_range(0, 20'hFFFFF));
        write_root({root_hi, $urandom});
        gen_walks(150);

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("%0d requests sent, %0d walks started, %0d table roots written",
                 n_sent, n_walks, n_roots);
        $display("%0d results matched (%0d done, %0d faults), %0d drain pauses, %0d errors",
                 n_checked, n_done, n_fault, n_pauses, err_count);
        if (err_count == 0 && res_due_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
